@@ sv/sbbph_pkg.sv @@
// Shared types, constants and helpers for the spectrum band bargraph with peak hold.
package sbbph_pkg;

  localparam int BAND_COUNT = 8;
  localparam int BAND_W     = 3;
  localparam int BIN_W      = 9;
  localparam int MAG_W      = 24;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 40;
  localparam int AGE_W      = 16;
  localparam int LVL_W      = 4;
  localparam int ROW_W      = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 4'd8;
  localparam logic [AGE_W-1:0] AGE_MAX   = 16'hFFFF;

  // Highest bin of each band; the lowest band starts at bin 1.
  localparam logic [BIN_W-1:0] BAND_TOP [BAND_COUNT] = '{
    9'd3, 9'd5, 9'd11, 9'd22, 9'd46, 9'd93, 9'd191, 9'd511
  };

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HOLD_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_HOLD_MS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_STEP_MS  = 2'd3;

  localparam logic [CFG_W-1:0] GAIN_RESET       = 16'd6554;
  localparam logic [CFG_W-1:0] LEVEL_HOLD_RESET = 16'd75;
  localparam logic [CFG_W-1:0] PEAK_HOLD_RESET  = 16'd500;
  localparam logic [CFG_W-1:0] PEAK_STEP_RESET  = 16'd50;

  typedef struct packed {
    logic [CFG_W-1:0] band_gain;
    logic [CFG_W-1:0] level_hold_ms;
    logic [CFG_W-1:0] peak_hold_ms;
    logic [CFG_W-1:0] peak_step_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [LVL_W-1:0]        shown;
    logic [LVL_W-1:0]        peak;
    logic [AGE_W-1:0]        level_age;
    logic [AGE_W-1:0]        peak_age;
    logic [AGE_W-1:0]        decay_age;
  } band_state_t;

  typedef struct packed {
    logic [LVL_W-1:0] shown;
    logic [LVL_W-1:0] peak;
    logic             clr_level_age;
    logic             clr_peak_age;
    logic             clr_decay_age;
    logic [ROW_W-1:0] row_bits;
  } band_result_t;

  // Saturating increment of a millisecond age counter.
  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? a : a + 1'b1;
  endfunction

endpackage

@@ sv/sbbph_band_update.sv @@
// Per-band level, peak hold and decay update with bitmap row generation.
module sbbph_band_update (
  input  sbbph_pkg::cfg_t         cfg,
  input  sbbph_pkg::band_state_t  cur,
  output sbbph_pkg::band_result_t res
);
  import sbbph_pkg::*;

  logic [SUM_W-26:0] quot;
  logic [LVL_W-1:0]  new_level;
  logic [LVL_W-1:0]  shown;
  logic [LVL_W-1:0]  peak;
  logic [ROW_W-1:0]  bar_mask;
  logic [ROW_W-1:0]  peak_mask;

  // The level is the sum divided by 2^25; negative sums read as zero.
  assign quot = cur.sum[SUM_W-1:25];

  always_comb begin
    if (cur.sum[SUM_W-1]) begin
      new_level = '0;
    end else if (quot > (SUM_W-25)'(LEVEL_MAX)) begin
      new_level = LEVEL_MAX;
    end else begin
      new_level = quot[LVL_W-1:0];
    end
  end

  always_comb begin
    res.clr_level_age = 1'b0;
    res.clr_peak_age  = 1'b0;
    res.clr_decay_age = 1'b0;
    shown = cur.shown;
    peak  = cur.peak;
    if ((new_level > cur.shown) || (cur.level_age > cfg.level_hold_ms)) begin
      shown = new_level;
      res.clr_level_age = 1'b1;
    end
    if (shown > cur.peak) begin
      peak = shown;
      res.clr_peak_age = 1'b1;
    end else if ((cur.peak_age > cfg.peak_hold_ms) && (cur.decay_age > cfg.peak_step_ms)
                 && (cur.peak != '0)) begin
      peak = cur.peak - 1'b1;
      res.clr_decay_age = 1'b1;
    end
    res.shown = shown;
    res.peak  = peak;

    bar_mask = '0;
    for (int i = 0; i < ROW_W; i++) begin
      bar_mask[i] = (LVL_W'(i) < shown);
    end
    peak_mask = '0;
    if (peak > 4'd1) begin
      peak_mask[3'(peak - 1'b1)] = 1'b1;
    end
    res.row_bits = bar_mask | peak_mask;
  end

endmodule

@@ sv/spectrum_band_bargraph_peak_hold.sv @@
// Top level: band accumulation, tick aging and frame-end bargraph row output.
// A bin item passes through accept, multiply and accumulate, using the shared multiplier
// and the single accumulator adder. A tick is accepted, then ages one band per cycle
// through the shared age incrementers. A frame-end bin adds a row per band, one band per
// cycle through the shared update unit, each waiting while the output register is full.
// rst is synchronous: config registers return to defaults, all sums, levels, peaks and ages clear.
module spectrum_band_bargraph_peak_hold (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // bin_index [8:0], magnitude [32:9], zero fill [39:33]
  input  logic [sbbph_pkg::IN_DATA_W-1:0]     s_tdata,
  // req_type [0]
  input  logic                                s_tuser,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // band_row [2:0], row_bits [10:3], bar_level [14:11], peak_level [18:15], zero [23:19]
  output logic [sbbph_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [sbbph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbbph_pkg::CFG_W-1:0]         cfg_data
);
  import sbbph_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_TICK = 5'b01000,
    ST_ROW  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  cfg_t cfg;

  logic signed [SUM_W-1:0] band_sum     [BAND_COUNT];
  logic [LVL_W-1:0]        shown_level  [BAND_COUNT];
  logic [LVL_W-1:0]        held_peak    [BAND_COUNT];
  logic [AGE_W-1:0]        level_age_ms [BAND_COUNT];
  logic [AGE_W-1:0]        peak_age_ms  [BAND_COUNT];
  logic [AGE_W-1:0]        decay_age_ms [BAND_COUNT];

  logic [BAND_W-1:0]       idx;
  logic                    idx_last;
  logic signed [MAG_W-1:0] mag;
  logic [BAND_W-1:0]       bin_band;
  logic                    bin_hit;
  logic                    frame;
  logic signed [SUM_W-1:0] prod;

  logic [BIN_W-1:0]        in_bin;
  logic [BAND_W-1:0]       lookup_band;
  logic                    lookup_hit;
  logic signed [SUM_W:0]   prod_full;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    accept;
  logic                    row_go;
  band_state_t             cur;
  band_result_t            res;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign in_bin   = s_tdata[BIN_W-1:0];
  assign idx_last = (idx == BAND_W'(BAND_COUNT - 1));
  assign row_go   = (state == ST_ROW) && (!m_tvalid || m_tready);

  // Band lookup: the lowest band whose top bound covers the bin; bin zero has no band.
  always_comb begin
    lookup_band = '0;
    lookup_hit  = 1'b0;
    for (int b = BAND_COUNT - 1; b >= 0; b--) begin
      if (in_bin <= BAND_TOP[b]) begin
        lookup_band = BAND_W'(b);
        lookup_hit  = (in_bin != '0);
      end
    end
  end

  assign prod_full = mag * $signed({1'b0, cfg.band_gain});
  assign sum_ext   = {band_sum[bin_band][SUM_W-1], band_sum[bin_band]} + {prod[SUM_W-1], prod};

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  assign cur.sum       = band_sum[idx];
  assign cur.shown     = shown_level[idx];
  assign cur.peak      = held_peak[idx];
  assign cur.level_age = level_age_ms[idx];
  assign cur.peak_age  = peak_age_ms[idx];
  assign cur.decay_age = decay_age_ms[idx];

  sbbph_band_update u_band_update (
    .cfg (cfg),
    .cur (cur),
    .res (res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = s_tuser ? ST_TICK : ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = frame ? ST_ROW : ST_IDLE;
      ST_TICK: begin
        if (idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_ROW: begin
        if (row_go && idx_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_gain     <= GAIN_RESET;
      cfg.level_hold_ms <= LEVEL_HOLD_RESET;
      cfg.peak_hold_ms  <= PEAK_HOLD_RESET;
      cfg.peak_step_ms  <= PEAK_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BAND_GAIN:     cfg.band_gain     <= cfg_data;
        CFG_LEVEL_HOLD_MS: cfg.level_hold_ms <= cfg_data;
        CFG_PEAK_HOLD_MS:  cfg.peak_hold_ms  <= cfg_data;
        CFG_PEAK_STEP_MS:  cfg.peak_step_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input capture and the multiply stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      mag      <= s_tdata[BIN_W +: MAG_W];
      bin_band <= lookup_band;
      bin_hit  <= lookup_hit;
      frame    <= s_tlast;
    end
    if (state == ST_MUL) begin
      prod <= prod_full[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept || ((state == ST_ACC) && frame)) begin
      idx <= '0;
    end else if ((state == ST_TICK) || row_go) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        band_sum[b]     <= '0;
        shown_level[b]  <= '0;
        held_peak[b]    <= '0;
        level_age_ms[b] <= '0;
        peak_age_ms[b]  <= '0;
        decay_age_ms[b] <= '0;
      end
    end else begin
      if ((state == ST_ACC) && bin_hit) begin
        band_sum[bin_band] <= sum_sat;
      end
      if (state == ST_TICK) begin
        level_age_ms[idx] <= age_inc(level_age_ms[idx]);
        peak_age_ms[idx]  <= age_inc(peak_age_ms[idx]);
        decay_age_ms[idx] <= age_inc(decay_age_ms[idx]);
      end
      if (row_go) begin
        band_sum[idx]    <= '0;
        shown_level[idx] <= res.shown;
        held_peak[idx]   <= res.peak;
        if (res.clr_level_age) begin
          level_age_ms[idx] <= '0;
        end
        if (res.clr_peak_age) begin
          peak_age_ms[idx] <= '0;
        end
        if (res.clr_decay_age) begin
          decay_age_ms[idx] <= '0;
        end
      end
    end
  end

  // Output register: a finished row waits here while the next band is prepared.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (row_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_go) begin
      m_tdata <= {5'd0, res.peak, res.shown, res.row_bits, idx};
      m_tlast <= idx_last;
    end
  end

  a_levels_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[14:11] <= LEVEL_MAX) && (m_tdata[18:15] <= LEVEL_MAX)))
    else $error("output level above the bar height");

  a_last_row_band: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[2:0] == BAND_W'(BAND_COUNT - 1))))
    else $error("last row flag does not match the final band");

  a_row_end_idle: assert property (@(posedge clk) disable iff (rst)
    (row_go && idx_last) |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("frame update did not finish after the final band");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    row_go |=> (band_sum[$past(idx)] == '0))
    else $error("band accumulator not cleared after its row");

endmodule

@@ dv/sbbph_row_checker.sv @@
// Row checker: predicts the bargraph rows of the spectrum band block and compares them.
module sbbph_row_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // bin_index [8:0], magnitude [32:9], zero fill [39:33]
  input  logic [sbbph_pkg::IN_DATA_W-1:0] s_tdata,
  // req_type [0]
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // band_row [2:0], row_bits [10:3], bar_level [14:11], peak_level [18:15], zero [23:19]
  input  logic [sbbph_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [sbbph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbbph_pkg::CFG_W-1:0]     cfg_data,
  output int                              errors,
  output int                              pending
);
  import sbbph_pkg::*;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [ROW_W-1:0]  row_bits;
    logic [LVL_W-1:0]  bar;
    logic [LVL_W-1:0]  peak;
    logic              last;
  } bar_row_t;

  localparam longint ACC_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< (SUM_W - 1));

  logic [CFG_W-1:0]        gain, level_hold, peak_hold, peak_step;
  logic signed [SUM_W-1:0] acc [BAND_COUNT];
  logic [LVL_W-1:0]        bar_now [BAND_COUNT];
  logic [LVL_W-1:0]        peak_mark [BAND_COUNT];
  logic [AGE_W-1:0]        level_age [BAND_COUNT];
  logic [AGE_W-1:0]        peak_age [BAND_COUNT];
  logic [AGE_W-1:0]        decay_age [BAND_COUNT];
  bar_row_t                rows_due [$];
  int                      rows_seen;

  task automatic report(input string what);
    if (errors < 40) $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic int band_of(input logic [BIN_W-1:0] bin);
    if (bin == '0) return -1;
    for (int b = 0; b < BAND_COUNT; b++)
      if (bin <= BAND_TOP[b]) return b;
    return -1;
  endfunction

  task automatic accumulate_bin(input logic [BIN_W-1:0] bin, input logic signed [MAG_W-1:0] mag);
    int     b;
    longint total;
    b = band_of(bin);
    if (b >= 0) begin
      total = longint'(acc[b]) + longint'(mag) * longint'(gain);
      if (total > ACC_HI) total = ACC_HI;
      if (total < ACC_LO) total = ACC_LO;
      acc[b] = total[SUM_W-1:0];
    end
  endtask

  task automatic advance_ages();
    for (int b = 0; b < BAND_COUNT; b++) begin
      if (level_age[b] != AGE_MAX) level_age[b]++;
      if (peak_age[b] != AGE_MAX) peak_age[b]++;
      if (decay_age[b] != AGE_MAX) decay_age[b]++;
    end
  endtask

  // One row per band; the sum is read as level = floor(sum / 2^25), clamped to 0..8.
  task automatic refresh_bands();
    logic signed [SUM_W-1:0] q;
    logic [LVL_W-1:0]        level_in;
    logic [ROW_W:0]          fill;
    bar_row_t                row;
    for (int b = 0; b < BAND_COUNT; b++) begin
      level_in = '0;
      if (acc[b] > 0) begin
        q = acc[b] >>> 25;
        level_in = (q > 8) ? LEVEL_MAX : q[LVL_W-1:0];
      end
      if (level_in > bar_now[b] || level_age[b] > level_hold) begin
        bar_now[b] = level_in;
        level_age[b] = '0;
      end
      if (bar_now[b] > peak_mark[b]) begin
        peak_mark[b] = bar_now[b];
        peak_age[b] = '0;
      end else if (peak_age[b] > peak_hold && decay_age[b] > peak_step && peak_mark[b] != 0) begin
        peak_mark[b]--;
        decay_age[b] = '0;
      end
      fill = ((ROW_W + 1)'(1) << bar_now[b]) - 1'b1;
      row.band = b[BAND_W-1:0];
      row.row_bits = fill[ROW_W-1:0];
      if (peak_mark[b] > 1) row.row_bits[peak_mark[b] - 1] = 1'b1;
      row.bar = bar_now[b];
      row.peak = peak_mark[b];
      row.last = (b == BAND_COUNT - 1);
      rows_due.push_back(row);
      acc[b] = '0;
    end
  endtask

  task automatic check_row();
    bar_row_t want;
    rows_seen++;
    if (rows_due.size() == 0) begin
      report($sformatf("row %0d arrived with none expected, tdata %h", rows_seen, m_tdata));
      return;
    end
    want = rows_due.pop_front();
    if (m_tdata[2:0] !== want.band)
      report($sformatf("row %0d band_row %0d, expected %0d", rows_seen, m_tdata[2:0], want.band));
    if (m_tdata[10:3] !== want.row_bits)
      report($sformatf("row %0d band %0d row_bits %b, expected %b",
                       rows_seen, want.band, m_tdata[10:3], want.row_bits));
    if (m_tdata[14:11] !== want.bar)
      report($sformatf("row %0d band %0d bar_level %0d, expected %0d",
                       rows_seen, want.band, m_tdata[14:11], want.bar));
    if (m_tdata[18:15] !== want.peak)
      report($sformatf("row %0d band %0d peak_level %0d, expected %0d",
                       rows_seen, want.band, m_tdata[18:15], want.peak));
    if (m_tlast !== want.last)
      report($sformatf("row %0d band %0d last_row %b, expected %b",
                       rows_seen, want.band, m_tlast, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gain = GAIN_RESET;
      level_hold = LEVEL_HOLD_RESET;
      peak_hold = PEAK_HOLD_RESET;
      peak_step = PEAK_STEP_RESET;
      for (int b = 0; b < BAND_COUNT; b++) begin
        acc[b] = '0;
        bar_now[b] = '0;
        peak_mark[b] = '0;
        level_age[b] = '0;
        peak_age[b] = '0;
        decay_age[b] = '0;
      end
      rows_due.delete();
      rows_seen = 0;
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BAND_GAIN:     gain = cfg_data;
          CFG_LEVEL_HOLD_MS: level_hold = cfg_data;
          CFG_PEAK_HOLD_MS:  peak_hold = cfg_data;
          CFG_PEAK_STEP_MS:  peak_step = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          advance_ages();
        end else begin
          accumulate_bin(s_tdata[8:0], s_tdata[32:9]);
          if (s_tlast) refresh_bands();
        end
      end
      if (m_tvalid && m_tready) check_row();
    end
    pending <= rows_due.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the bench: clock, reset, stimulus for the spectrum band block and the verdict.
module testbench;
  import sbbph_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 30;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready, s_tuser, s_tlast;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid, m_tready, m_tlast;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  int                    errors, pending;
  int                    cycles;
  int                    sent;
  int                    send_idle, take_idle;

  spectrum_band_bargraph_peak_hold dut (.*);
  sbbph_row_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL spectrum_band_bargraph_peak_hold");
      $finish;
    end
  end

  always @(negedge clk) m_tready = ($urandom_range(99) >= take_idle);

  task automatic push_item(input logic tick, input logic [BIN_W-1:0] bin,
                           input logic [MAG_W-1:0] mag, input logic frame_end);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = tick;
    s_tdata = {7'd0, mag, bin};
    s_tlast = frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic push_tick();
    push_item(1'b1, 9'($urandom), 24'($urandom), 1'($urandom));
  endtask

  // Holds the stream until every expected row is out and the block has gone quiet.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] lh,
                            input logic [CFG_W-1:0] ph, input logic [CFG_W-1:0] ps);
    drain();
    write_reg(CFG_BAND_GAIN, g);
    write_reg(CFG_LEVEL_HOLD_MS, lh);
    write_reg(CFG_PEAK_HOLD_MS, ph);
    write_reg(CFG_PEAK_STEP_MS, ps);
  endtask

  // Mostly bins inside a chosen band, the rest anywhere including bin zero.
  function automatic logic [BIN_W-1:0] rand_bin();
    int b, lo;
    if ($urandom_range(3) == 0) return 9'($urandom);
    b = $urandom_range(BAND_COUNT - 1);
    lo = (b == 0) ? 1 : int'(BAND_TOP[b-1]) + 1;
    return 9'($urandom_range(int'(BAND_TOP[b]), lo));
  endfunction

  // Random width spreads the sums over all levels instead of pinning them at the clamp.
  function automatic logic [MAG_W-1:0] rand_mag();
    logic [MAG_W-1:0] m;
    int               w;
    w = $urandom_range(MAG_W);
    m = 24'($urandom) & ((24'd1 << w) - 24'd1);
    if ($urandom_range(3) == 0) m = -m;
    return m;
  endfunction

  task automatic run_random(input int count);
    int goal, k, r;
    goal = sent + count;
    while (sent < goal) begin
      r = $urandom_range(99);
      if (r < 70) begin
        repeat ($urandom_range(3)) push_tick();
        k = $urandom_range(10, 1);
        for (int i = 0; i < k; i++) push_item(1'b0, rand_bin(), rand_mag(), i == k - 1);
      end else if (r < 85) begin
        repeat ($urandom_range(20, 1)) push_tick();
      end else begin
        push_item(1'($urandom), 9'($urandom), 24'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BAND_GAIN;
    cfg_data = '0;
    sent = 0;
    send_idle = 7;
    take_idle = 52;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Reset settings: full-scale values, bin zero and a frame end on a bin outside all bands.
    push_item(1'b0, 9'd1, 24'h7FFFFF, 1'b0);
    push_item(1'b0, 9'd3, 24'h800000, 1'b0);
    push_item(1'b0, 9'd0, 24'h7FFFFF, 1'b0);
    push_item(1'b0, 9'd511, 24'h7FFFFF, 1'b0);
    push_item(1'b0, 9'd5, 24'h000001, 1'b0);
    push_item(1'b0, 9'd12, 24'h010000, 1'b0);
    push_item(1'b1, 9'h1FF, 24'h800000, 1'b1);
    push_item(1'b0, 9'd0, 24'h000000, 1'b1);

    // Full gain with zero holds: accumulator saturation both ways and immediate decay.
    set_config(16'hFFFF, 16'd0, 16'd0, 16'd0);
    push_item(1'b0, 9'd2, 24'h7FFFFF, 1'b0);
    push_item(1'b0, 9'd2, 24'h7FFFFF, 1'b0);
    push_item(1'b0, 9'd2, 24'h800000, 1'b0);
    push_item(1'b0, 9'd4, 24'h800000, 1'b0);
    push_item(1'b0, 9'd5, 24'h800000, 1'b0);
    push_item(1'b0, 9'd5, 24'h800000, 1'b0);
    push_item(1'b0, 9'd46, 24'h00FFFF, 1'b0);
    push_item(1'b0, 9'd47, 24'h7FFFFF, 1'b0);
    push_item(1'b0, 9'd192, 24'h000800, 1'b1);
    push_item(1'b1, 9'd0, 24'h000000, 1'b0);
    push_item(1'b0, 9'd6, 24'h000000, 1'b1);
    push_item(1'b1, 9'd94, 24'h7FFFFF, 1'b0);
    push_item(1'b0, 9'd300, 24'h800000, 1'b1);

    // Zero gain: a full-scale bin still gives level zero.
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    push_item(1'b0, 9'd1, 24'h7FFFFF, 1'b1);

    set_config(16'($urandom_range(20000, 2000)), 16'($urandom_range(8)),
               16'($urandom_range(30)), 16'($urandom_range(6)));
    run_random(60);
    drain();
    run_random(60);

    send_idle = 52;
    take_idle = 7;
    set_config(16'($urandom), 16'($urandom_range(15)),
               16'($urandom_range(15)), 16'($urandom_range(4)));
    run_random(125);

    send_idle = 0;
    take_idle = 0;
    set_config(16'($urandom_range(65535, 30000)), 16'($urandom_range(4)),
               16'($urandom_range(40)), 16'($urandom_range(10)));
    run_random(125);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("PASS spectrum_band_bargraph_peak_hold");
    end else begin
      $display("FAIL spectrum_band_bargraph_peak_hold");
    end
    $finish;
  end

endmodule

@@ spectrum_band_bargraph_peak_hold.f @@
sv/sbbph_pkg.sv
sv/sbbph_band_update.sv
sv/spectrum_band_bargraph_peak_hold.sv
dv/sbbph_row_checker.sv
dv/testbench.sv
